FILE: hdl/crr_pkg.sv
// crr_pkg: types and constants of the control response reassembler.
// No dependencies; used by every module of the block.
package crr_pkg;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;
    localparam logic [1:0] OP_RXERR   = 2'd3;

    localparam logic [2:0] OUT_SUCCESS = 3'd0;
    localparam logic [2:0] OUT_TIMEOUT = 3'd1;
    localparam logic [2:0] OUT_RXERR   = 3'd2;
    localparam logic [2:0] OUT_SERVER  = 3'd3;
    localparam logic [2:0] OUT_LIMIT   = 3'd4;

    localparam logic CFG_SEQUENCE = 1'b0;
    localparam logic CFG_LIMIT    = 1'b1;

    localparam int HDR_LEN = 12;
    localparam logic [2:0] MODE_MASK    = 3'h7;
    localparam logic [2:0] CONTROL_MODE = 3'd6;
    localparam int RESP_BIT      = 7;
    localparam int SRV_FAULT_BIT = 6;
    localparam int FRAG_CONT_BIT = 5;
    localparam logic [7:0] LIMIT_RESET = 8'd16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic        has_write;
        logic        has_report;
        logic [16:0] address;
        logic [7:0]  data;
        logic [2:0]  outcome;
        logic [7:0]  fragments;
        logic [4:0]  opcode;
        logic [15:0] status;
        logic [15:0] association;
        logic [16:0] length;
    } crr_rec_t;

endpackage

FILE: hdl/crr_front.sv
// crr_front: parses datagram bytes and classifies each input transfer
// into a result record. Depends on crr_pkg.
module crr_front import crr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    input  logic        end_of_datagram,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        rec_valid,
    output crr_rec_t    rec
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_ACCEPT = 2'd2;
    localparam logic [1:0] PH_DROP   = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [7:0]  hdr_reg [HDR_LEN];
    logic [7:0]  hdr_next [HDR_LEN];
    logic [7:0]  dg_reg, dg_next;
    logic [7:0]  frag_reg, frag_next;
    logic        seen_reg, seen_next;
    logic [16:0] ext_reg, ext_next;
    logic [4:0]  opc_reg, opc_next;
    logic [15:0] status_reg, status_next;
    logic [15:0] assoc_reg, assoc_next;
    logic [15:0] seq_reg;
    logic [7:0]  limit_reg;

    always_comb
    begin
        logic        ok;
        logic        server;
        logic [15:0] idx;
        logic [15:0] offs;
        logic [15:0] cnt;
        logic [16:0] addr;
        logic [2:0]  rep_code;
        logic        do_rep;

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        hdr_next    = hdr_reg;
        dg_next     = dg_reg;
        frag_next   = frag_reg;
        seen_next   = seen_reg;
        ext_next    = ext_reg;
        opc_next    = opc_reg;
        status_next = status_reg;
        assoc_next  = assoc_reg;
        rec         = '0;
        do_rep      = 1'b0;
        rep_code    = OUT_SUCCESS;
        server      = 1'b0;
        ok          = 1'b0;
        offs        = {hdr_reg[8], hdr_reg[9]};
        cnt         = {hdr_reg[10], hdr_reg[11]};
        idx         = pos_reg - 16'(HDR_LEN);
        addr        = {1'b0, offs} + {1'b0, idx};

        if (accept)
        begin
            if (op == OP_START)
            begin
                phase_next  = PH_HEADER;
                pos_next    = '0;
                dg_next     = '0;
                frag_next   = '0;
                seen_next   = 1'b0;
                ext_next    = '0;
                opc_next    = '0;
                status_next = '0;
                assoc_next  = '0;
                if (limit_reg == 8'd0)
                begin
                    do_rep   = 1'b1;
                    rep_code = OUT_LIMIT;
                end
            end
            else if (phase_reg == PH_IDLE)
            begin
            end
            else if (op == OP_TIMEOUT)
            begin
                do_rep   = 1'b1;
                rep_code = seen_reg ? OUT_SUCCESS : OUT_TIMEOUT;
            end
            else if (op == OP_RXERR)
            begin
                do_rep   = 1'b1;
                rep_code = seen_reg ? OUT_SUCCESS : OUT_RXERR;
            end
            else
            begin
                if (pos_reg < 16'(HDR_LEN))
                begin
                    hdr_next[pos_reg[3:0]] = rx_byte;
                    if (pos_reg == 16'(HDR_LEN - 1) && phase_reg == PH_HEADER)
                    begin
                        ok = ((hdr_reg[0][2:0] & MODE_MASK) == CONTROL_MODE)
                            && ({hdr_reg[2], hdr_reg[3]} == seq_reg)
                            && hdr_reg[1][RESP_BIT];
                        if (ok)
                        begin
                            seen_next   = 1'b1;
                            opc_next    = hdr_reg[1][4:0];
                            status_next = {hdr_reg[4], hdr_reg[5]};
                            assoc_next  = {hdr_reg[6], hdr_reg[7]};
                            if (frag_reg != 8'hFF)
                                frag_next = frag_reg + 8'd1;
                            if (hdr_reg[1][SRV_FAULT_BIT])
                            begin
                                server   = 1'b1;
                                do_rep   = 1'b1;
                                rep_code = OUT_SERVER;
                            end
                            else
                            begin
                                phase_next = PH_ACCEPT;
                                if ({1'b0, offs} > ext_reg)
                                    ext_next = {1'b0, offs};
                            end
                        end
                        else
                        begin
                            phase_next = PH_DROP;
                        end
                    end
                end
                else if (phase_reg == PH_ACCEPT && pos_reg != 16'hFFFF)
                begin
                    if (idx < cnt)
                    begin
                        rec.has_write = 1'b1;
                        rec.address   = addr;
                        rec.data      = rx_byte;
                        if (addr + 17'd1 > ext_reg)
                            ext_next = addr + 17'd1;
                    end
                end
                if (!server)
                begin
                    if (pos_reg != 16'hFFFF)
                        pos_next = pos_reg + 16'd1;
                    if (end_of_datagram)
                    begin
                        pos_next = '0;
                        if (phase_next == PH_ACCEPT && !hdr_reg[1][FRAG_CONT_BIT])
                        begin
                            do_rep   = 1'b1;
                            rep_code = OUT_SUCCESS;
                        end
                        else
                        begin
                            if (dg_reg != 8'hFF)
                                dg_next = dg_reg + 8'd1;
                            if (dg_next >= limit_reg)
                            begin
                                do_rep   = 1'b1;
                                rep_code = seen_next ? OUT_SUCCESS : OUT_LIMIT;
                            end
                            else
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                    end
                end
            end

            if (do_rep)
            begin
                phase_next      = PH_IDLE;
                pos_next        = '0;
                rec.has_report  = 1'b1;
                rec.outcome     = rep_code;
                rec.fragments   = frag_next;
                rec.opcode      = opc_next;
                rec.status      = status_next;
                rec.association = assoc_next;
                rec.length      = (rep_code == OUT_SERVER) ? 17'd0 : ext_next;
            end
        end
        rec_valid = rec.has_write | rec.has_report;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            dg_reg     <= '0;
            frag_reg   <= '0;
            seen_reg   <= 1'b0;
            ext_reg    <= '0;
            opc_reg    <= '0;
            status_reg <= '0;
            assoc_reg  <= '0;
            seq_reg    <= '0;
            limit_reg  <= LIMIT_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            dg_reg     <= dg_next;
            frag_reg   <= frag_next;
            seen_reg   <= seen_next;
            ext_reg    <= ext_next;
            opc_reg    <= opc_next;
            status_reg <= status_next;
            assoc_reg  <= assoc_next;
            if (cfg_write)
            begin
                if (cfg_index == CFG_SEQUENCE)
                    seq_reg <= cfg_data;
                else
                    limit_reg <= cfg_data[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

endmodule

FILE: hdl/crr_back.sv
// crr_back: record queue and result unpacking; a record with a write
// and a report gives two result transfers. Depends on crr_pkg.
module crr_back import crr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rec_valid,
    input  crr_rec_t    rec,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [16:0] write_address,
    output logic [7:0]  write_data,
    output logic [2:0]  outcome,
    output logic [7:0]  fragment_total,
    output logic [4:0]  reply_opcode,
    output logic [15:0] reply_status,
    output logic [15:0] reply_association,
    output logic [16:0] data_length,
    output logic        last_of_run
);

    crr_rec_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_reg, rd_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic                 half_reg;
    crr_rec_t             head;
    logic                 show_write;
    logic                 take;
    logic                 advance;

    assign head       = mem_reg[rd_reg];
    assign empty      = (count_reg == '0);
    assign full       = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign show_write = head.has_write && !half_reg;
    assign take       = pop && !empty;
    assign advance    = take && !(show_write && head.has_report);

    always_comb
    begin
        kind              = !show_write;
        write_address     = show_write ? head.address : 17'd0;
        write_data        = show_write ? head.data : 8'd0;
        outcome           = show_write ? 3'd0 : head.outcome;
        fragment_total    = show_write ? 8'd0 : head.fragments;
        reply_opcode      = show_write ? 5'd0 : head.opcode;
        reply_status      = show_write ? 16'd0 : head.status;
        reply_association = show_write ? 16'd0 : head.association;
        data_length       = show_write ? 17'd0 : head.length;
        last_of_run       = !(show_write && head.has_report);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
            half_reg  <= 1'b0;
        end
        else
        begin
            if (rec_valid)
                wr_reg <= wr_reg + 1'b1;
            if (advance)
                rd_reg <= rd_reg + 1'b1;
            count_reg <= count_reg + (QUEUE_AW+1)'(rec_valid) - (QUEUE_AW+1)'(advance);
            if (advance)
                half_reg <= 1'b0;
            else if (take)
                half_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_valid)
            mem_reg[wr_reg] <= rec;
    end

endmodule

FILE: hdl/control_response_reassembler_unit.sv
// control_response_reassembler_unit: top level of the control response
// reassembler. Depends on crr_pkg, crr_front and crr_back.
//
// channel  | handshake           | payload
// input    | push / full         | op, rx_byte, end_of_datagram
// result   | empty / pop         | kind .. last_of_run
// config   | cfg_write           | cfg_index, cfg_data
//
// One input transfer per cycle while full is low; the front classifies it in the cycle it is
// taken and writes any record that it gives into a four-entry queue.
// A record gives one or two result transfers, one per cycle while pop is high.
// full rises only when the queue holds four records; stalled results fill the queue and then stall the input.
// Reset clears the parser state, the counters and the queue.
module control_response_reassembler_unit import crr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    input  logic        end_of_datagram,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [16:0] write_address,
    output logic [7:0]  write_data,
    output logic [2:0]  outcome,
    output logic [7:0]  fragment_total,
    output logic [4:0]  reply_opcode,
    output logic [15:0] reply_status,
    output logic [15:0] reply_association,
    output logic [16:0] data_length,
    output logic        last_of_run,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic     rec_valid;
    crr_rec_t rec;

    crr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (push && !full),
        .op              (op),
        .rx_byte         (rx_byte),
        .end_of_datagram (end_of_datagram),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rec_valid       (rec_valid),
        .rec             (rec)
    );

    crr_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .rec_valid         (rec_valid),
        .rec               (rec),
        .full              (full),
        .empty             (empty),
        .pop               (pop),
        .kind              (kind),
        .write_address     (write_address),
        .write_data        (write_data),
        .outcome           (outcome),
        .fragment_total    (fragment_total),
        .reply_opcode      (reply_opcode),
        .reply_status      (reply_status),
        .reply_association (reply_association),
        .data_length       (data_length),
        .last_of_run       (last_of_run)
    );

endmodule

FILE: hdl/crr_checker.sv
// crr_checker: port-level checks of control_response_reassembler_unit,
// attached by bind. Depends on crr_pkg.
module crr_checker import crr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        kind,
    input logic [2:0]  outcome,
    input logic [7:0]  fragment_total,
    input logic [16:0] data_length,
    input logic        last_of_run
);

    a_write_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !kind) |-> (outcome == OUT_SUCCESS && data_length == 17'd0))
        else $error("write transfer carries report fields");

    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind) |-> last_of_run)
        else $error("report transfer not last of run");

    a_server_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind && outcome == OUT_SERVER) |-> (data_length == 17'd0))
        else $error("server error report with data length");

    a_none_frags: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind && (outcome == OUT_TIMEOUT || outcome == OUT_RXERR
            || outcome == OUT_LIMIT)) |-> (fragment_total == 8'd0))
        else $error("no-response report with fragments");

endmodule

bind control_response_reassembler_unit crr_checker u_crr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .kind           (kind),
    .outcome        (outcome),
    .fragment_total (fragment_total),
    .data_length    (data_length),
    .last_of_run    (last_of_run)
);

FILE: tb/sv/tb_control_response_reassembler_unit.sv
// Testbench for control_response_reassembler_unit: directed and random datagram traffic,
// checked against a behavioral predictor with a queue of expected result transfers.
// Depends on crr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_control_response_reassembler_unit;
    import crr_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [16:0] address;
        logic [7:0]  data;
        logic [2:0]  outcome;
        logic [7:0]  fragments;
        logic [4:0]  opcode;
        logic [15:0] status;
        logic [15:0] association;
        logic [16:0] length;
        logic        last;
    } result_t;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_ACCEPT = 2'd2;
    localparam logic [1:0] PH_DROP   = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic        end_of_datagram;
    logic        empty;
    logic        pop;
    logic        kind;
    logic [16:0] write_address;
    logic [7:0]  write_data;
    logic [2:0]  outcome;
    logic [7:0]  fragment_total;
    logic [4:0]  reply_opcode;
    logic [15:0] reply_status;
    logic [15:0] reply_association;
    logic [16:0] data_length;
    logic        last_of_run;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;

    control_response_reassembler_unit dut (.*);

    // predictor state
    logic [15:0] seq_reg;
    logic [7:0]  limit_reg;
    logic [1:0]  phase;
    logic [15:0] byte_pos;
    logic [7:0]  hdr [HDR_LEN];
    logic [7:0]  dgram_count;
    logic [7:0]  frag_count;
    logic        got_response;
    logic [16:0] extent;
    logic [4:0]  last_opcode;
    logic [15:0] last_status;
    logic [15:0] last_assoc;

    result_t     expected_results[$];
    int          errors;
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          idle_cycles;
    bit          sender_bursty;
    bit          long_hold;
    bit          timed_out;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    function automatic logic [15:0] hdr_word(int i);
        return {hdr[i], hdr[i + 1]};
    endfunction

    task automatic push_report(logic [2:0] oc);
        result_t r;
        r = '0;
        r.kind = 1'b1;
        r.outcome = oc;
        r.fragments = frag_count;
        r.opcode = last_opcode;
        r.status = last_status;
        r.association = last_assoc;
        r.length = (oc == OUT_SERVER) ? 17'd0 : extent;
        expected_results.insert(expected_results.size(), r);
        phase = PH_IDLE;
        byte_pos = '0;
    endtask

    task automatic clear_transaction();
        phase = PH_IDLE;
        byte_pos = '0;
        for (int i = 0; i < HDR_LEN; i++)
            hdr[i] = '0;
        dgram_count = '0;
        frag_count = '0;
        got_response = 1'b0;
        extent = '0;
        last_opcode = '0;
        last_status = '0;
        last_assoc = '0;
    endtask

    task automatic predict_reassembly(logic [1:0] o, logic [7:0] b, logic eod);
        int n0;
        int p;
        int idx;
        logic [16:0] addr;
        result_t r;
        bit done;
        n0 = expected_results.size();
        done = 0;
        if (o == OP_START)
        begin
            clear_transaction();
            phase = PH_HEADER;
            if (limit_reg == 0)
                push_report(OUT_LIMIT);
        end
        else if (phase == PH_IDLE)
        begin
        end
        else if (o == OP_TIMEOUT)
            push_report(got_response ? OUT_SUCCESS : OUT_TIMEOUT);
        else if (o == OP_RXERR)
            push_report(got_response ? OUT_SUCCESS : OUT_RXERR);
        else
        begin
            p = byte_pos;
            if (p < HDR_LEN)
            begin
                hdr[p] = b;
                if (p == HDR_LEN - 1 && phase == PH_HEADER)
                begin
                    if ((hdr[0][2:0] == CONTROL_MODE) && hdr_word(2) == seq_reg
                        && hdr[1][RESP_BIT])
                    begin
                        got_response = 1'b1;
                        last_opcode = hdr[1][4:0];
                        last_status = hdr_word(4);
                        last_assoc = hdr_word(6);
                        if (frag_count != 8'hFF)
                            frag_count++;
                        if (hdr[1][SRV_FAULT_BIT])
                        begin
                            push_report(OUT_SERVER);
                            done = 1;
                        end
                        else
                        begin
                            phase = PH_ACCEPT;
                            if ({1'b0, hdr_word(8)} > extent)
                                extent = {1'b0, hdr_word(8)};
                        end
                    end
                    else
                        phase = PH_DROP;
                end
            end
            else if (phase == PH_ACCEPT && p != 16'hFFFF)
            begin
                idx = p - HDR_LEN;
                if (idx < hdr_word(10))
                begin
                    addr = 17'(hdr_word(8) + idx);
                    r = '0;
                    r.address = addr;
                    r.data = b;
                    expected_results.insert(expected_results.size(), r);
                    if (addr + 17'd1 > extent)
                        extent = addr + 17'd1;
                end
            end
            if (!done)
            begin
                if (p != 16'hFFFF)
                    byte_pos = 16'(p + 1);
                if (eod)
                begin
                    byte_pos = '0;
                    if (phase == PH_ACCEPT && !hdr[1][FRAG_CONT_BIT])
                        push_report(OUT_SUCCESS);
                    else
                    begin
                        if (dgram_count != 8'hFF)
                            dgram_count++;
                        if (dgram_count >= limit_reg)
                            push_report(got_response ? OUT_SUCCESS : OUT_LIMIT);
                        else
                            phase = PH_HEADER;
                    end
                end
            end
        end
        if (expected_results.size() > n0)
            expected_results[$].last = 1'b1;
    endtask

    // One item, offered at the falling edge until taken; push stays high
    // until the next item or a drain takes over at the same falling edge.
    task automatic send_item(logic [1:0] o, logic [7:0] b, logic eod);
        if (sender_bursty && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        push <= 1'b1;
        op <= o;
        rx_byte <= b;
        end_of_datagram <= eod;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_reassembly(o, b, eod);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_results.size() != 0 && !timed_out)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_SEQUENCE)
            seq_reg = val;
        else
            limit_reg = val[7:0];
    endtask

    // Sends one datagram; flags steer header validity.
    task automatic send_datagram(bit good, logic [7:0] flags, logic [15:0] offset,
                                 logic [15:0] count, int payload_len, int cut);
        logic [7:0] h [HDR_LEN];
        int total;
        int i;
        logic [15:0] w;
        h[0] = good ? {5'($urandom_range(0, 31)), CONTROL_MODE} : 8'($urandom());
        h[1] = flags;
        w = good ? seq_reg : 16'($urandom());
        h[2] = w[15:8];
        h[3] = w[7:0];
        w = 16'($urandom());
        h[4] = w[15:8];
        h[5] = w[7:0];
        w = 16'($urandom());
        h[6] = w[15:8];
        h[7] = w[7:0];
        h[8] = offset[15:8];
        h[9] = offset[7:0];
        h[10] = count[15:8];
        h[11] = count[7:0];
        total = (cut > 0) ? cut : HDR_LEN + payload_len;
        for (i = 0; i < total; i++)
            send_item(OP_BYTE, (i < HDR_LEN) ? h[i] : 8'($urandom()), i == total - 1);
    endtask

    function automatic logic [7:0] rand_flags();
        logic [7:0] f;
        f = 8'($urandom());
        f[RESP_BIT] = ($urandom_range(0, 9) != 0);
        f[SRV_FAULT_BIT] = ($urandom_range(0, 9) == 0);
        return f;
    endfunction

    task automatic test_directed();
        write_reg(CFG_SEQUENCE, 16'h1234);
        send_item(OP_BYTE, 8'hFF, 1'b1);
        send_item(OP_TIMEOUT, 8'h00, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        send_datagram(1, 8'hBF, 16'hFFFF, 16'hFFFF, 3, 0);
        send_datagram(1, 8'h80, 16'h0000, 16'h0002, 4, 0);
        send_item(OP_START, 8'h00, 1'b0);
        send_datagram(1, 8'hE0, 16'h0010, 16'h0004, 0, 0);
        send_item(OP_START, 8'h00, 1'b0);
        send_datagram(1, 8'h00, 16'h0, 16'h1, 1, 0);
        send_item(OP_TIMEOUT, 8'h00, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        send_datagram(1, 8'hA0, 16'h0, 16'h1, 0, 5);
        send_item(OP_RXERR, 8'h00, 1'b0);
        send_item(OP_START, 8'h00, 1'b0);
        send_datagram(1, 8'hA0, 16'h0100, 16'h0, 0, 0);
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_TIMEOUT, 8'h00, 1'b0);
        write_reg(CFG_LIMIT, 16'd0);
        send_item(OP_START, 8'h00, 1'b0);
        write_reg(CFG_LIMIT, 16'd1);
        send_item(OP_START, 8'h00, 1'b0);
        send_datagram(0, 8'h00, 16'h0, 16'h0, 0, 0);
    endtask

    task automatic test_random_transactions(int budget);
        int target;
        target = items_sent + budget;
        sender_bursty = 1;
        while (items_sent < target && !timed_out)
        begin
            send_item(OP_START, 8'h00, 1'b0);
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 9))
                    0: send_datagram(1, rand_flags(), 16'($urandom()), 16'($urandom()),
                                     $urandom_range(0, 6), 0);
                    1: send_datagram(1, rand_flags(), 16'($urandom_range(0, 40)), 16'd4, 0,
                                     $urandom_range(1, 11));
                    2: send_datagram(0, rand_flags(), 16'd0, 16'd3, 3, 0);
                    3: send_item(2'($urandom_range(2, 3)), 8'($urandom()), 1'($urandom()));
                    4: send_item(OP_BYTE, 8'($urandom()), 1'($urandom()));
                    default: send_datagram(1, rand_flags(), 16'($urandom_range(0, 300)),
                                           16'($urandom_range(0, 8)),
                                           $urandom_range(0, 10), 0);
                endcase
            end
            if ($urandom_range(0, 3) == 0)
                send_item(2'($urandom_range(2, 3)), 8'h00, 1'b0);
        end
        sender_bursty = 0;
    endtask

    task automatic test_backpressure();
        long_hold = 1;
        write_reg(CFG_SEQUENCE, 16'hFFFF);
        write_reg(CFG_LIMIT, 16'd2);
        send_item(OP_START, 8'h00, 1'b0);
        send_datagram(1, 8'hA0, 16'h0020, 16'h0010, 16, 0);
        long_hold = 0;
        wait_drained();
    endtask

    // receiver: random stalls, occasional long hold-off
    initial
    begin
        int hold;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                pop <= 1'b0;
                for (hold = 0; hold < 60; hold++)
                    @(negedge clk);
                while (long_hold)
                begin
                    pop <= 1'b1;
                    @(negedge clk);
                end
            end
            pop <= ($urandom_range(0, 15) < 11) || (($urandom_range(0, 63)) == 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t got;
        result_t exp;
        if (rst_n && pop && !empty)
        begin
            got = {kind, write_address, write_data, outcome, fragment_total, reply_opcode,
                   reply_status, reply_association, data_length, last_of_run};
            results_seen++;
            if (expected_results.size() == 0)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", got);
            end
            else
            begin
                exp = expected_results.pop_front();
                if (got !== exp)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp, got);
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        op = OP_START;
        rx_byte = '0;
        end_of_datagram = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_SEQUENCE;
        cfg_data = '0;
        errors = 0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        idle_cycles = 0;
        sender_bursty = 0;
        long_hold = 0;
        timed_out = 0;
        seq_reg = '0;
        limit_reg = LIMIT_RESET;
        clear_transaction();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        write_reg(CFG_LIMIT, 16'd255);
        write_reg(CFG_SEQUENCE, 16'($urandom()));
        test_random_transactions(600);
        test_backpressure();
        write_reg(CFG_LIMIT, 16'd3);
        write_reg(CFG_SEQUENCE, 16'h0000);
        test_random_transactions(450);
        write_reg(CFG_LIMIT, 16'd16);
        test_random_transactions(400);
        wait_drained();
        $display("Covered %0d input transfers and %0d result transfers", items_sent,
                 results_seen);
        $display("over directed cases, random transactions, limits and back-pressure.");
        if (errors == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
